>>> hw/rtl/m68kl5_pkg.sv
// Package for the 68000 line-5 execute pipeline: opcode field codes,
// instruction class enum, pipeline stage structs and the condition test.
// No dependencies.
package m68kl5_pkg;

  // Opcode line and field codes
  localparam logic [3:0] LINE_5     = 4'h5;
  localparam logic [1:0] SIZE_BYTE  = 2'd0;
  localparam logic [1:0] SIZE_WORD  = 2'd1;
  localparam logic [1:0] SIZE_LONG  = 2'd2;
  localparam logic [1:0] SIZE_CTRL  = 2'd3;
  localparam logic [2:0] MODE_DN    = 3'd0;
  localparam logic [2:0] MODE_AN    = 3'd1;
  localparam logic [2:0] MODE_EXT   = 3'd7;
  localparam logic [2:0] REG_ABS_L  = 3'd1;
  localparam logic [2:0] REG_TRAP_W = 3'd2;
  localparam logic [2:0] REG_TRAP_L = 3'd3;
  localparam logic [2:0] REG_TRAP   = 3'd4;

  // Condition codes
  localparam logic [3:0] CC_T  = 4'd0;
  localparam logic [3:0] CC_F  = 4'd1;
  localparam logic [3:0] CC_HI = 4'd2;
  localparam logic [3:0] CC_LS = 4'd3;
  localparam logic [3:0] CC_CC = 4'd4;
  localparam logic [3:0] CC_CS = 4'd5;
  localparam logic [3:0] CC_NE = 4'd6;
  localparam logic [3:0] CC_EQ = 4'd7;
  localparam logic [3:0] CC_VC = 4'd8;
  localparam logic [3:0] CC_VS = 4'd9;
  localparam logic [3:0] CC_PL = 4'd10;
  localparam logic [3:0] CC_MI = 4'd11;
  localparam logic [3:0] CC_GE = 4'd12;
  localparam logic [3:0] CC_LT = 4'd13;
  localparam logic [3:0] CC_GT = 4'd14;
  localparam logic [3:0] CC_LE = 4'd15;

  // CCR bit positions
  localparam int unsigned FLAG_X = 4;
  localparam int unsigned FLAG_N = 3;
  localparam int unsigned FLAG_Z = 2;
  localparam int unsigned FLAG_V = 1;
  localparam int unsigned FLAG_C = 0;

  // Instruction class after decode
  typedef enum logic [2:0] {
    KIND_ILL,
    KIND_ADDQ_AN,
    KIND_ADDQ_EA,
    KIND_DBCC,
    KIND_SCC,
    KIND_TRAP
  } kind_e;

  // Decode stage register
  typedef struct packed {
    kind_e       kind;
    logic        cond;
    logic        we;
    logic        sub;
    logic [1:0]  size;
    logic        dn;
    logic [3:0]  imm;
    logic [4:0]  flags;
    logic [31:0] opnd;
    logic [31:0] addr;
    logic [31:0] off;
  } dec_t;

  // Arithmetic stage register
  typedef struct packed {
    kind_e       kind;
    logic        cond;
    logic        we;
    logic        sub;
    logic [1:0]  size;
    logic        dn;
    logic [3:0]  imm;
    logic [4:0]  flags;
    logic [31:0] opnd;
    logic [31:0] a;
    logic [31:0] r;
    logic [31:0] an_res;
    logic [15:0] cnt;
    logic [31:0] next;
  } ex_t;

  // Evaluate one of the 16 standard conditions against the CCR
  function automatic logic m5_cond(input logic [3:0] cc, input logic [4:0] f);
    logic n, z, v, c, res;
    n = f[FLAG_N];
    z = f[FLAG_Z];
    v = f[FLAG_V];
    c = f[FLAG_C];
    case (cc)
      CC_T:    res = 1'b1;
      CC_F:    res = 1'b0;
      CC_HI:   res = !c && !z;
      CC_LS:   res = c || z;
      CC_CC:   res = !c;
      CC_CS:   res = c;
      CC_NE:   res = !z;
      CC_EQ:   res = z;
      CC_VC:   res = !v;
      CC_VS:   res = v;
      CC_PL:   res = !n;
      CC_MI:   res = n;
      CC_GE:   res = (n == v);
      CC_LT:   res = (n != v);
      CC_GT:   res = !z && (n == v);
      default: res = z || (n != v);
    endcase
    return res;
  endfunction

  // Operand mask for a size code
  function automatic logic [31:0] m5_mask(input logic [1:0] size);
    logic [31:0] m;
    case (size)
      SIZE_BYTE: m = 32'h0000_00ff;
      SIZE_WORD: m = 32'h0000_ffff;
      default:   m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

  // Sign bit for a size code
  function automatic logic [31:0] m5_msb(input logic [1:0] size);
    logic [31:0] m;
    case (size)
      SIZE_BYTE: m = 32'h0000_0080;
      SIZE_WORD: m = 32'h0000_8000;
      default:   m = 32'h8000_0000;
    endcase
    return m;
  endfunction

endpackage

>>> hw/rtl/m68k_line5_execute.sv
// Top level of the 68000 line-5 execute pipeline (ADDQ, SUBQ, Scc, DBcc, TRAPcc).
// Three register stages: decode, arithmetic, flags and write-back select.
// Depends on m68kl5_pkg.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_stall_o  instr_word, displacement, instr_addr,
//                                              flags_in, operand
//   out      output     out_valid_o/out_stall_i write_value, write_enable, next_addr,
//                                              flags_out, trap_taken, illegal
//
// One request enters per cycle while in_stall_o is low; each result passes through the
// three stages in turn: decode, adders, flags and result select.
// Reset clears the stage valid bits only; payload registers are not reset.
// A stall on the output holds the last stage and backs up into earlier stages
// only as far as they are full; in_stall_o rises once all three stages hold requests
// while the output is stalled.
module m68k_line5_execute
  import m68kl5_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] instr_word_i,
  input  logic [15:0] displacement_i,
  input  logic [31:0] instr_addr_i,
  input  logic [4:0]  flags_in_i,
  input  logic [31:0] operand_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] write_value_o,
  output logic        write_enable_o,
  output logic [31:0] next_addr_o,
  output logic [4:0]  flags_out_o,
  output logic        trap_taken_o,
  output logic        illegal_o
);

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  dec_t dec_d, dec_q;
  ex_t  ex_d, ex_q;

  logic [31:0] wval_d, wval_q;
  logic        we_d, we_q;
  logic [31:0] next_d, next_q;
  logic [4:0]  fout_d, fout_q;
  logic        trap_d, trap_q;
  logic        ill_d, ill_q;

  // Stage ready: a stage loads when empty or when its content moves on
  assign rdy3 = !v3_q || !out_stall_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  // Decode: classify the word, test the condition, pick the PC offset
  always_comb begin
    logic [1:0] size;
    logic [2:0] mode;
    logic [2:0] rg;
    size = instr_word_i[7:6];
    mode = instr_word_i[5:3];
    rg   = instr_word_i[2:0];

    dec_d.kind  = KIND_ILL;
    dec_d.cond  = m5_cond(instr_word_i[11:8], flags_in_i);
    dec_d.we    = 1'b0;
    dec_d.sub   = instr_word_i[8];
    dec_d.size  = size;
    dec_d.dn    = (mode == MODE_DN);
    dec_d.imm   = (instr_word_i[11:9] == 3'd0) ? 4'd8 : {1'b0, instr_word_i[11:9]};
    dec_d.flags = flags_in_i;
    dec_d.opnd  = operand_i;
    dec_d.addr  = instr_addr_i;
    dec_d.off   = 32'd0;

    if (instr_word_i[15:12] != LINE_5) begin
      dec_d.kind = KIND_ILL;
    end else if (size != SIZE_CTRL) begin
      if ((mode == MODE_EXT && rg > REG_ABS_L) || (mode == MODE_AN && size == SIZE_BYTE)) begin
        dec_d.kind = KIND_ILL;
      end else begin
        dec_d.kind = (mode == MODE_AN) ? KIND_ADDQ_AN : KIND_ADDQ_EA;
        dec_d.we   = 1'b1;
        dec_d.off  = 32'd2;
      end
    end else if (mode == MODE_AN) begin
      dec_d.kind = KIND_DBCC;
      if (dec_d.cond) begin
        dec_d.off = 32'd4;
      end else begin
        dec_d.we = 1'b1;
        // counter expires when the low word wraps from zero
        if (operand_i[15:0] == 16'd0) begin
          dec_d.off = 32'd4;
        end else begin
          dec_d.off = {{16{displacement_i[15]}}, displacement_i} + 32'd2;
        end
      end
    end else if (mode != MODE_EXT || rg <= REG_ABS_L) begin
      dec_d.kind = KIND_SCC;
      dec_d.we   = 1'b1;
      dec_d.off  = 32'd2;
    end else begin
      case (rg)
        REG_TRAP_W: begin
          dec_d.kind = KIND_TRAP;
          dec_d.off  = 32'd4;
        end
        REG_TRAP_L: begin
          dec_d.kind = KIND_TRAP;
          dec_d.off  = 32'd6;
        end
        REG_TRAP: begin
          dec_d.kind = KIND_TRAP;
          dec_d.off  = 32'd2;
        end
        default: dec_d.kind = KIND_ILL;
      endcase
    end
  end

  // Arithmetic: sized add/subtract, address add, counter decrement, next PC
  always_comb begin
    logic [31:0] mask;
    logic [31:0] imm32;
    mask  = m5_mask(dec_q.size);
    imm32 = {28'd0, dec_q.imm};

    ex_d.kind   = dec_q.kind;
    ex_d.cond   = dec_q.cond;
    ex_d.we     = dec_q.we;
    ex_d.sub    = dec_q.sub;
    ex_d.size   = dec_q.size;
    ex_d.dn     = dec_q.dn;
    ex_d.imm    = dec_q.imm;
    ex_d.flags  = dec_q.flags;
    ex_d.opnd   = dec_q.opnd;
    ex_d.a      = dec_q.opnd & mask;
    ex_d.r      = (dec_q.sub ? ex_d.a - imm32 : ex_d.a + imm32) & mask;
    ex_d.an_res = dec_q.sub ? dec_q.opnd - imm32 : dec_q.opnd + imm32;
    ex_d.cnt    = dec_q.opnd[15:0] - 16'd1;
    ex_d.next   = dec_q.addr + dec_q.off;
  end

  // Result select: flags from the sized result, merge into the destination
  always_comb begin
    logic [31:0] mask;
    logic [31:0] msb;
    logic [31:0] imm32;
    logic [7:0]  sbyte;
    logic        carry, ovf;
    mask  = m5_mask(ex_q.size);
    msb   = m5_msb(ex_q.size);
    imm32 = {28'd0, ex_q.imm};
    sbyte = ex_q.cond ? 8'hff : 8'h00;

    if (ex_q.sub) begin
      carry = imm32 > ex_q.a;
      ovf   = ((ex_q.a ^ imm32) & (ex_q.a ^ ex_q.r) & msb) != 32'd0;
    end else begin
      carry = ex_q.r < ex_q.a;
      ovf   = ((~(ex_q.a ^ imm32)) & (ex_q.a ^ ex_q.r) & msb) != 32'd0;
    end

    wval_d = 32'd0;
    we_d   = ex_q.we;
    next_d = ex_q.next;
    fout_d = ex_q.flags;
    trap_d = 1'b0;
    ill_d  = 1'b0;

    case (ex_q.kind)
      KIND_ADDQ_AN: wval_d = ex_q.an_res;
      KIND_ADDQ_EA: begin
        wval_d = ex_q.dn ? ((ex_q.opnd & ~mask) | ex_q.r) : ex_q.r;
        fout_d[FLAG_C] = carry;
        fout_d[FLAG_X] = carry;
        fout_d[FLAG_V] = ovf;
        fout_d[FLAG_Z] = (ex_q.r == 32'd0);
        fout_d[FLAG_N] = (ex_q.r & msb) != 32'd0;
      end
      KIND_SCC: wval_d = ex_q.dn ? {ex_q.opnd[31:8], sbyte} : {24'd0, sbyte};
      KIND_DBCC: begin
        if (ex_q.we) begin
          wval_d = {ex_q.opnd[31:16], ex_q.cnt};
        end
      end
      KIND_TRAP: trap_d = ex_q.cond;
      default: begin
        ill_d  = 1'b1;
        we_d   = 1'b0;
        next_d = ex_q.next;
      end
    endcase
  end

  // Advance stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Advance stage payloads; hold while stalled
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) dec_q <= dec_d;
    if (rdy2 && v1_q) ex_q <= ex_d;
    if (rdy3 && v2_q) begin
      wval_q <= wval_d;
      we_q   <= we_d;
      next_q <= next_d;
      fout_q <= fout_d;
      trap_q <= trap_d;
      ill_q  <= ill_d;
    end
  end

  assign out_valid_o    = v3_q;
  assign write_value_o  = wval_q;
  assign write_enable_o = we_q;
  assign next_addr_o    = next_q;
  assign flags_out_o    = fout_q;
  assign trap_taken_o   = trap_q;
  assign illegal_o      = ill_q;

  // Input stalls only when every stage holds a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q))
    else $error("input stalled with an empty stage");

  // Illegal words neither write nor trap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && illegal_o) |-> (!write_enable_o && !trap_taken_o))
    else $error("illegal result writes or traps");

  // No write means a zero write value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !write_enable_o) |-> (write_value_o == 32'd0))
    else $error("write value nonzero without write");

  // A taken trap never writes a destination
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && trap_taken_o) |-> !write_enable_o)
    else $error("trap result also writes");

  // A request in the middle stage reaches the output register when it is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && rdy3) |=> v3_q)
    else $error("request lost between stages");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for m68k_line5_execute: directed and random line-5 requests,
// checked field by field against a local predictor, under random and long output stalls.
// Depends on m68kl5_pkg and the m68k_line5_execute RTL.
`timescale 1ns / 100ps

module tb_top;
  import m68kl5_pkg::*;

  // Opcode fields the package leaves unnamed
  localparam logic       OP_ADD         = 1'b0;
  localparam logic       OP_SUB         = 1'b1;
  localparam logic [2:0] MODE_IND       = 3'd2;
  localparam logic [2:0] MODE_DISP      = 3'd5;
  localparam logic [2:0] REG_ABS_W      = 3'd0;
  localparam logic [2:0] REG_RSV_FIRST  = 3'd5;
  localparam logic [2:0] REG_RSV_LAST   = 3'd7;

  localparam int N_RANDOM      = 1125;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int HOLD_CYCLES   = 64;
  localparam int HOLD_SPACING  = 500;
  localparam int MAX_PRINTS    = 40;

  typedef struct {
    logic [15:0] word;
    logic [15:0] disp;
    logic [31:0] addr;
    logic [4:0]  flags;
    logic [31:0] opnd;
    int unsigned gap;
    bit          drain;
  } line5_req_t;

  typedef struct {
    logic [31:0] value;
    logic        we;
    logic [31:0] next;
    logic [4:0]  flags;
    logic        trap;
    logic        ill;
  } line5_res_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic [15:0] instr_word_i   = '0;
  logic [15:0] displacement_i = '0;
  logic [31:0] instr_addr_i   = '0;
  logic [4:0]  flags_in_i     = '0;
  logic [31:0] operand_i      = '0;
  wire         in_stall_o;
  wire         out_valid_o;
  wire         out_stall_i;
  wire  [31:0] write_value_o;
  wire         write_enable_o;
  wire  [31:0] next_addr_o;
  wire  [4:0]  flags_out_o;
  wire         trap_taken_o;
  wire         illegal_o;

  line5_req_t  req_q[$];
  line5_res_t  line5_exp_q[$];
  line5_req_t  cur_req;
  line5_res_t  want;
  int          n_queued      = 0;
  int          n_sent        = 0;
  int          n_total       = 0;
  int          n_checked     = 0;
  int          n_errors      = 0;
  int          n_illegal     = 0;
  int          n_traps       = 0;
  int          n_in_stalls   = 0;
  int          n_holds       = 0;
  int          tx_seen       = 0;
  int          hold_seen     = 0;
  int          next_hold_at  = 250;
  int          cycle_cnt     = 0;
  int unsigned tx_gap        = 0;
  int unsigned rx_wait       = 0;
  int unsigned hold_left     = 0;

  m68k_line5_execute u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .instr_word_i   (instr_word_i),
    .displacement_i (displacement_i),
    .instr_addr_i   (instr_addr_i),
    .flags_in_i     (flags_in_i),
    .operand_i      (operand_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .write_value_o  (write_value_o),
    .write_enable_o (write_enable_o),
    .next_addr_o    (next_addr_o),
    .flags_out_o    (flags_out_o),
    .trap_taken_o   (trap_taken_o),
    .illegal_o      (illegal_o)
  );

  // Stall the output on the per-result wait or during a long hold
  assign out_stall_i = (rx_wait != 0) || (hold_left != 0);

  initial forever #1 clk_i = ~clk_i;

  // Evaluate a condition code against the CCR
  function automatic logic cond_holds(input logic [3:0] cc, input logic [4:0] f);
    logic n, z, v, c;
    n = f[FLAG_N];
    z = f[FLAG_Z];
    v = f[FLAG_V];
    c = f[FLAG_C];
    case (cc)
      CC_T:    return 1'b1;
      CC_F:    return 1'b0;
      CC_HI:   return !c && !z;
      CC_LS:   return c || z;
      CC_CC:   return !c;
      CC_CS:   return c;
      CC_NE:   return !z;
      CC_EQ:   return z;
      CC_VC:   return !v;
      CC_VS:   return v;
      CC_PL:   return !n;
      CC_MI:   return n;
      CC_GE:   return n == v;
      CC_LT:   return n != v;
      CC_GT:   return !z && (n == v);
      default: return z || (n != v);
    endcase
  endfunction

  // Compute the result of one line-5 request
  function automatic line5_res_t predict_line5(input line5_req_t rq);
    line5_res_t  rs;
    logic [1:0]  size;
    logic [2:0]  mode, rg;
    logic [3:0]  cc;
    logic [31:0] imm, mask, msb, a, r, sdisp;
    logic [15:0] cnt;
    logic        sub, carry, ovf, hit;
    size = rq.word[7:6];
    mode = rq.word[5:3];
    rg   = rq.word[2:0];
    cc   = rq.word[11:8];
    hit  = cond_holds(cc, rq.flags);
    rs.value = '0;
    rs.we    = 1'b0;
    rs.next  = rq.addr;
    rs.flags = rq.flags;
    rs.trap  = 1'b0;
    rs.ill   = 1'b0;
    if (rq.word[15:12] != LINE_5) begin
      rs.ill = 1'b1;
    end else if (size != SIZE_CTRL) begin
      imm = (rq.word[11:9] == 3'd0) ? 32'd8 : {29'd0, rq.word[11:9]};
      sub = rq.word[8];
      if ((mode == MODE_EXT && rg > REG_ABS_L) || (mode == MODE_AN && size == SIZE_BYTE)) begin
        rs.ill = 1'b1;
      end else if (mode == MODE_AN) begin
        // Address register: full 32-bit add, CCR untouched
        rs.value = sub ? rq.opnd - imm : rq.opnd + imm;
        rs.we    = 1'b1;
        rs.next  = rq.addr + 32'd2;
      end else begin
        case (size)
          SIZE_BYTE: begin mask = 32'h0000_00ff; msb = 32'h0000_0080; end
          SIZE_WORD: begin mask = 32'h0000_ffff; msb = 32'h0000_8000; end
          default:   begin mask = 32'hffff_ffff; msb = 32'h8000_0000; end
        endcase
        a = rq.opnd & mask;
        r = (sub ? a - imm : a + imm) & mask;
        if (sub) begin
          carry = imm > a;
          ovf   = |((a ^ imm) & (a ^ r) & msb);
        end else begin
          carry = r < a;
          ovf   = |(~(a ^ imm) & (a ^ r) & msb);
        end
        rs.flags         = '0;
        rs.flags[FLAG_C] = carry;
        rs.flags[FLAG_X] = carry;
        rs.flags[FLAG_V] = ovf;
        rs.flags[FLAG_Z] = (r == 32'd0);
        rs.flags[FLAG_N] = |(r & msb);
        rs.value = (mode == MODE_DN) ? ((rq.opnd & ~mask) | r) : r;
        rs.we    = 1'b1;
        rs.next  = rq.addr + 32'd2;
      end
    end else if (mode == MODE_AN) begin
      // Decrement and branch: count down the low word unless the condition holds
      if (hit) begin
        rs.next = rq.addr + 32'd4;
      end else begin
        cnt      = rq.opnd[15:0] - 16'd1;
        sdisp    = {{16{rq.disp[15]}}, rq.disp};
        rs.value = {rq.opnd[31:16], cnt};
        rs.we    = 1'b1;
        rs.next  = (cnt == 16'hffff) ? rq.addr + 32'd4 : rq.addr + 32'd2 + sdisp;
      end
    end else if (mode != MODE_EXT || rg <= REG_ABS_L) begin
      rs.value = (mode == MODE_DN) ? {rq.opnd[31:8], {8{hit}}} : {24'd0, {8{hit}}};
      rs.we    = 1'b1;
      rs.next  = rq.addr + 32'd2;
    end else if (rg == REG_TRAP_W || rg == REG_TRAP_L || rg == REG_TRAP) begin
      rs.next = rq.addr + ((rg == REG_TRAP_W) ? 32'd4 : (rg == REG_TRAP_L) ? 32'd6 : 32'd2);
      rs.trap = hit;
    end else begin
      rs.ill = 1'b1;
    end
    return rs;
  endfunction

  function automatic logic [15:0] l5_word(input logic [3:0] hi, input logic [1:0] size,
                                          input logic [2:0] mode, input logic [2:0] rg);
    return {LINE_5, hi, size, mode, rg};
  endfunction

  // Queue one request; keep a burst with no idling, pause for a drain twice
  task automatic push_req(input logic [15:0] word, input logic [15:0] disp,
                          input logic [31:0] addr, input logic [4:0] flags,
                          input logic [31:0] opnd);
    line5_req_t rq;
    rq.word  = word;
    rq.disp  = disp;
    rq.addr  = addr;
    rq.flags = flags;
    rq.opnd  = opnd;
    rq.gap   = (n_queued >= 400 && n_queued < 560) ? 0 : $urandom_range(0, 9);
    rq.drain = (n_queued == 600 || n_queued == 900);
    req_q.push_back(rq);
    n_queued++;
  endtask

  // Pick an operand, often near the carry and overflow boundaries of each size
  function automatic logic [31:0] pick_operand();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 7))
      3: r[7:0]  = {1'($urandom_range(0, 1)), 7'd0} + 8'($urandom_range(0, 17)) - 8'd9;
      4: r[15:0] = {1'($urandom_range(0, 1)), 15'd0} + 16'($urandom_range(0, 17)) - 16'd9;
      5: r       = {1'($urandom_range(0, 1)), 31'd0} + $urandom_range(0, 17) - 32'd9;
      6: r[15:0] = 16'($urandom_range(0, 3));
      7: r       = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
      default: ;
    endcase
    return r;
  endfunction

  task automatic push_random_req();
    logic [15:0] word;
    logic [31:0] addr;
    logic [2:0]  mode;
    logic [2:0]  rg;
    addr = $urandom();
    if ($urandom_range(0, 15) == 0) addr = 32'hffff_fff0 + $urandom_range(0, 15);
    mode = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 19))
      0, 1: begin
        word = 16'($urandom_range(0, 65535));
      end
      2, 3, 4, 5, 6, 7: begin
        rg = (mode == MODE_EXT) ? 3'($urandom_range(0, 3)) : 3'($urandom_range(0, 7));
        word = l5_word(4'($urandom_range(0, 15)), 2'($urandom_range(0, 2)), mode, rg);
      end
      8, 9, 10: begin
        word = l5_word(4'($urandom_range(0, 15)), SIZE_CTRL, MODE_AN, 3'($urandom_range(0, 7)));
      end
      11, 12, 13, 14: begin
        if (mode == MODE_AN) mode = MODE_IND;
        rg = (mode == MODE_EXT) ? 3'($urandom_range(0, 1)) : 3'($urandom_range(0, 7));
        word = l5_word(4'($urandom_range(0, 15)), SIZE_CTRL, mode, rg);
      end
      15, 16, 17: begin
        rg = 3'($urandom_range(REG_TRAP_W, REG_TRAP));
        word = l5_word(4'($urandom_range(0, 15)), SIZE_CTRL, MODE_EXT, rg);
      end
      default: begin
        word = l5_word(4'($urandom_range(0, 15)), SIZE_CTRL, mode, 3'($urandom_range(0, 7)));
      end
    endcase
    push_req(word, 16'($urandom_range(0, 65535)), addr, 5'($urandom_range(0, 31)),
             pick_operand());
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    n_errors++;
    if (n_errors <= MAX_PRINTS)
      $display("tb: mismatch on %s at result %0d: got %h, want %h",
               what, n_checked, got, exp_val);
  endtask

  // Drive requests from the pending queue, idling and draining as each item asks
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_gap     <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) tx_seen++;
      if (in_valid_i && in_stall_o) n_in_stalls++;
      if (in_valid_i && !in_stall_o) begin
        line5_exp_q.push_back(predict_line5(cur_req));
        n_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (tx_gap != 0) begin
          tx_gap     <= tx_gap - 1;
          in_valid_i <= 1'b0;
        end else if (req_q.size() != 0 && !(req_q[0].drain && n_sent != tx_seen)) begin
          cur_req        = req_q.pop_front();
          instr_word_i   <= cur_req.word;
          displacement_i <= cur_req.disp;
          instr_addr_i   <= cur_req.addr;
          flags_in_i     <= cur_req.flags;
          operand_i      <= cur_req.opnd;
          in_valid_i     <= 1'b1;
          tx_gap         <= cur_req.gap;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Hold the output off for a long stretch every few hundred results
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) hold_seen++;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (hold_seen >= next_hold_at) begin
        hold_left    <= HOLD_CYCLES;
        next_hold_at <= next_hold_at + HOLD_SPACING;
        n_holds++;
      end
    end
  end

  // Check each accepted result against the oldest prediction, then draw the next wait
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rx_wait <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      if (line5_exp_q.size() == 0) begin
        report_mismatch("unexpected result", write_value_o, 32'd0);
      end else begin
        want = line5_exp_q.pop_front();
        if (write_value_o !== want.value) report_mismatch("write_value", write_value_o, want.value);
        if (write_enable_o !== want.we)
          report_mismatch("write_enable", {31'd0, write_enable_o}, {31'd0, want.we});
        if (next_addr_o !== want.next) report_mismatch("next_addr", next_addr_o, want.next);
        if (flags_out_o !== want.flags)
          report_mismatch("flags_out", {27'd0, flags_out_o}, {27'd0, want.flags});
        if (trap_taken_o !== want.trap)
          report_mismatch("trap_taken", {31'd0, trap_taken_o}, {31'd0, want.trap});
        if (illegal_o !== want.ill)
          report_mismatch("illegal", {31'd0, illegal_o}, {31'd0, want.ill});
        if (want.ill) n_illegal++;
        if (want.trap) n_traps++;
      end
      n_checked++;
      rx_wait <= (n_checked >= 420 && n_checked < 580) ? 0 : $urandom_range(0, 9);
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("tb: timeout after %0d cycles, %0d results still due", cycle_cnt,
               line5_exp_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    int k;
    // Directed: field extremes, every instruction form and each corner case
    push_req(16'h0000, 16'h0000, 32'h0000_0100, 5'h00, 32'h0000_0000);
    push_req(16'hffff, 16'hffff, 32'hffff_ffff, 5'h1f, 32'hffff_ffff);
    push_req(l5_word({3'd0, OP_ADD}, SIZE_BYTE, MODE_DN, 3'd0), 16'h0, 32'h1000, 5'h00,
             32'h1234_56f8);
    push_req(l5_word({3'd1, OP_ADD}, SIZE_BYTE, MODE_DN, 3'd7), 16'h0, 32'h1002, 5'h1f,
             32'hffff_ff7f);
    push_req(l5_word({3'd1, OP_SUB}, SIZE_BYTE, MODE_DN, 3'd3), 16'h0, 32'h1004, 5'h00,
             32'haaaa_aa00);
    push_req(l5_word({3'd1, OP_SUB}, SIZE_BYTE, MODE_IND, 3'd2), 16'h0, 32'h1006, 5'h00,
             32'h0000_0080);
    push_req(l5_word({3'd7, OP_ADD}, SIZE_WORD, MODE_DN, 3'd1), 16'h0, 32'h1008, 5'h00,
             32'hffff_7fff);
    push_req(l5_word({3'd0, OP_SUB}, SIZE_LONG, MODE_EXT, REG_ABS_L), 16'h0, 32'h100a, 5'h1f,
             32'h0000_0000);
    push_req(l5_word({3'd3, OP_ADD}, SIZE_LONG, MODE_EXT, REG_ABS_W), 16'h0, 32'hffff_fffe,
             5'h00, 32'hffff_ffff);
    push_req(l5_word({3'd2, OP_ADD}, SIZE_BYTE, MODE_AN, 3'd0), 16'h0, 32'h100c, 5'h0a,
             32'h0000_00ff);
    push_req(l5_word({3'd0, OP_ADD}, SIZE_WORD, MODE_AN, 3'd5), 16'h0, 32'h100e, 5'h15,
             32'hffff_fffc);
    push_req(l5_word({3'd1, OP_SUB}, SIZE_LONG, MODE_AN, 3'd7), 16'h0, 32'h1010, 5'h00,
             32'h0000_0000);
    push_req(l5_word({3'd4, OP_ADD}, SIZE_WORD, MODE_EXT, REG_TRAP_W), 16'h0, 32'h1012, 5'h03,
             32'h0000_1234);
    push_req(l5_word(CC_T, SIZE_CTRL, MODE_DN, 3'd0), 16'h0, 32'h1014, 5'h00, 32'h1234_5600);
    push_req(l5_word(CC_F, SIZE_CTRL, MODE_DN, 3'd4), 16'h0, 32'h1016, 5'h1f, 32'hffff_ffff);
    push_req(l5_word(CC_EQ, SIZE_CTRL, MODE_DISP, 3'd1), 16'h0, 32'h1018, 5'h04,
             32'h5555_5555);
    push_req(l5_word(CC_LE, SIZE_CTRL, MODE_EXT, REG_ABS_L), 16'h0, 32'h101a, 5'h08,
             32'h0000_0000);
    push_req(l5_word(CC_T, SIZE_CTRL, MODE_AN, 3'd2), 16'h0010, 32'h101c, 5'h00,
             32'h0000_0003);
    push_req(l5_word(CC_F, SIZE_CTRL, MODE_AN, 3'd3), 16'h0040, 32'h101e, 5'h00,
             32'habcd_0000);
    push_req(l5_word(CC_F, SIZE_CTRL, MODE_AN, 3'd0), 16'h8000, 32'h0000_0000, 5'h00,
             32'h0000_0005);
    push_req(l5_word(CC_NE, SIZE_CTRL, MODE_AN, 3'd1), 16'h7ffe, 32'hffff_fffe, 5'h04,
             32'h0001_0001);
    push_req(l5_word(CC_T, SIZE_CTRL, MODE_EXT, REG_TRAP_W), 16'h0, 32'hffff_fffe, 5'h00,
             32'h0);
    push_req(l5_word(CC_F, SIZE_CTRL, MODE_EXT, REG_TRAP_L), 16'h0, 32'hffff_fffc, 5'h1f,
             32'h0);
    push_req(l5_word(CC_GT, SIZE_CTRL, MODE_EXT, REG_TRAP), 16'h0, 32'h1020, 5'h00, 32'h0);
    push_req(l5_word(CC_VS, SIZE_CTRL, MODE_EXT, REG_RSV_FIRST), 16'h0, 32'h1022, 5'h02,
             32'h0);
    push_req(l5_word(CC_MI, SIZE_CTRL, MODE_EXT, REG_RSV_LAST), 16'h0, 32'h1024, 5'h08,
             32'h0);
    // Random: mostly well-formed line-5 words with random content, some noise
    for (k = 0; k < N_RANDOM; k++) push_random_req();
    n_total = n_queued;

    // Hold reset low, then release it
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for all requests to go in and all results to come out
    while (n_sent != n_total) @(posedge clk_i);
    while (line5_exp_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("tb: %0d requests, %0d results checked, %0d illegal, %0d traps taken",
             n_sent, n_checked, n_illegal, n_traps);
    $display("tb: %0d long output holds, %0d cycles with the input stalled, %0d mismatches",
             n_holds, n_in_stalls, n_errors);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
